// ===== src/rcl_pkg.sv =====
// rcl_pkg: types and constants of the command line parser
// shared by the channel interface users and the parser top level; no dependencies
`default_nettype none

package rcl_pkg;

   localparam int AccWidth = 16;
   localparam logic [AccWidth-1:0] AccMax = {AccWidth{1'b1}};

   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_IGNORE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      LK_NONE   = 2'd0,
      LK_LENGTH = 2'd1,
      LK_DATA   = 2'd2,
      LK_DROP   = 2'd3
   } line_kind_type;

   typedef enum logic [1:0] {
      KIND_COUNT = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_command;
   } req_payload_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      value;
      logic [5:0]      param_index;
      logic            last;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== src/rcl_channel_if.sv =====
// rcl_channel_if: valid/ready channel carrying one payload beat
// payload type is a parameter; used with the types of rcl_pkg
`default_nettype none

interface rcl_channel_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/resp_command_line_parser.sv =====
// resp_command_line_parser: request-array command parser, one byte per beat
// depends on rcl_pkg and rcl_channel_if
`default_nettype none

// Takes one command byte per req beat and returns the parameter count, the
// parameter bytes and an end marker per parameter on the rsp channel. A byte
// is parsed in the cycle it is accepted and its results (none, one or two)
// go into a four-entry result queue; rsp is driven from that queue. A byte
// is accepted every cycle while at least two queue entries are free, so the
// sustained rate is one byte per cycle as long as rsp is ready and the
// bytes give at most one result each; a byte that gives two results (a
// held carriage return flushed with the byte, or the final byte of a line
// plus its end marker) takes two entries, which the single rsp port sends
// one per cycle while rsp is ready. No clearing pass after reset.
module resp_command_line_parser
   import rcl_pkg::*;
#(
   parameter int MAX_PARAMS = 64,
   parameter int MAX_LENGTH = 65535
) (
   input  wire logic    clock,
   input  wire logic    reset,
   rcl_channel_if.sink   req_if,
   rcl_channel_if.source rsp_if
);

   localparam int CntW = $clog2(MAX_PARAMS + 1);
   localparam int LenW = $clog2(MAX_LENGTH + 1);
   localparam logic [AccWidth-1:0] MaxParamsAcc = AccWidth'(MAX_PARAMS);
   localparam logic [AccWidth-1:0] MaxLengthAcc = AccWidth'(MAX_LENGTH);
   localparam int QDepth = 4;

   // parser state
   phase_type           phase_ff, phase_in;
   logic                at_line_start_ff, at_line_start_in;
   line_kind_type       line_kind_ff, line_kind_in;
   logic                digits_done_ff, digits_done_in;
   logic [AccWidth-1:0] number_ff, number_in;
   logic [CntW-1:0]     param_total_ff, param_total_in;
   logic [CntW-1:0]     param_counter_ff, param_counter_in;
   logic [LenW-1:0]     declared_length_ff, declared_length_in;
   logic [LenW-1:0]     bytes_in_line_ff, bytes_in_line_in;
   logic                held_valid_ff, held_valid_in;

   // result queue
   rsp_payload_type     queue_ff [QDepth];
   logic [1:0]          head_ff, head_in;
   logic [2:0]          count_ff, count_in;

   rsp_payload_type     res [2];
   logic [1:0]          res_n;

   logic                accept, pop;
   logic [7:0]          c;
   logic                eoc, nl, is_digit;
   logic                header_close;
   logic [AccWidth-1:0] number_step;
   logic                digits_done_step;
   logic [AccWidth+3:0] number_wide;

   assign accept = req_if.valid && req_if.ready;
   assign pop    = rsp_if.valid && rsp_if.ready;
   assign req_if.ready   = (count_ff <= 3'd2);
   assign rsp_if.valid   = (count_ff != 3'd0);
   assign rsp_if.payload = queue_ff[head_ff];

   assign c        = req_if.payload.data_byte;
   assign eoc      = req_if.payload.end_of_command;
   assign nl       = (c == CHAR_LF);
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

   // one decimal digit step on the current accumulator
   assign number_wide = ({4'b0, number_ff} << 3) + ({4'b0, number_ff} << 1)
                      + (AccWidth+4)'(c - CHAR_ZERO);
   always_comb begin
      number_step      = number_ff;
      digits_done_step = digits_done_ff;
      if (!digits_done_ff) begin
         if (is_digit) begin
            number_step = (number_wide > {4'b0, AccMax}) ? AccMax
                                                         : number_wide[AccWidth-1:0];
         end else begin
            digits_done_step = 1'b1;
         end
      end
   end

   assign header_close = (phase_ff == PH_HEADER) && (nl || eoc)
                       && !(at_line_start_ff && (c != CHAR_STAR));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (eoc) begin
            phase_in = PH_HEADER;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (at_line_start_ff && (c != CHAR_STAR)) begin
                     phase_in = PH_IGNORE;
                  end else if (header_close) begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY:   phase_in = PH_BODY;
               PH_IGNORE: phase_in = PH_IGNORE;
               default:   phase_in = PH_HEADER;
            endcase
         end
      end
   end

   // line state, counters and results of the accepted byte
   always_comb begin
      logic [CntW-1:0] count_sat;
      logic            content;

      at_line_start_in   = at_line_start_ff;
      line_kind_in       = line_kind_ff;
      digits_done_in     = digits_done_ff;
      number_in          = number_ff;
      param_total_in     = param_total_ff;
      param_counter_in   = param_counter_ff;
      declared_length_in = declared_length_ff;
      bytes_in_line_in   = bytes_in_line_ff;
      held_valid_in      = held_valid_ff;
      res[0]  = '{kind: KIND_COUNT, value: 8'd0, param_index: 6'd0, last: 1'b0};
      res[1]  = '{kind: KIND_COUNT, value: 8'd0, param_index: 6'd0, last: 1'b0};
      res_n   = 2'd0;
      content = 1'b1;
      count_sat = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (at_line_start_ff) begin
                  at_line_start_in = 1'b0;
                  number_in        = '0;
                  digits_done_in   = 1'b0;
               end else if (!nl) begin
                  number_in      = number_step;
                  digits_done_in = digits_done_step;
               end
               if (header_close) begin
                  count_sat = (number_in > MaxParamsAcc) ? CntW'(MAX_PARAMS)
                                                         : CntW'(number_in);
                  res[res_n[0]] = '{kind: KIND_COUNT, value: 8'(count_sat),
                                    param_index: 6'd0, last: 1'b0};
                  res_n = res_n + 2'd1;
                  param_total_in   = count_sat;
                  at_line_start_in = 1'b1;
               end
            end
            PH_BODY: begin
               if (at_line_start_ff) begin
                  at_line_start_in = 1'b0;
                  bytes_in_line_in = '0;
                  held_valid_in    = 1'b0;
                  number_in        = '0;
                  digits_done_in   = 1'b0;
                  if (c == CHAR_DOLLAR) begin
                     line_kind_in = LK_LENGTH;
                     content      = 1'b0;
                  end else if ((declared_length_ff != '0)
                               && (param_counter_ff < param_total_ff)) begin
                     line_kind_in = LK_DATA;
                  end else begin
                     line_kind_in = LK_DROP;
                  end
               end
               if (content) begin
                  if (line_kind_in == LK_LENGTH) begin
                     if (!nl) begin
                        number_in      = number_step;
                        digits_done_in = digits_done_step;
                     end
                  end else if (line_kind_in == LK_DATA) begin
                     // a held byte is always a carriage return
                     priority if (nl) begin
                        held_valid_in = 1'b0;
                     end else if (eoc && held_valid_in && (c != CHAR_CR)) begin
                        held_valid_in = 1'b0;
                        if (bytes_in_line_in < declared_length_ff) begin
                           res[res_n[0]] = '{kind: KIND_DATA, value: c,
                                             param_index: 6'(param_counter_ff), last: 1'b0};
                           res_n = res_n + 2'd1;
                           bytes_in_line_in = bytes_in_line_in + 1'b1;
                        end
                     end else if (c == CHAR_CR) begin
                        if (held_valid_in && (bytes_in_line_in < declared_length_ff)) begin
                           res[res_n[0]] = '{kind: KIND_DATA, value: CHAR_CR,
                                             param_index: 6'(param_counter_ff), last: 1'b0};
                           res_n = res_n + 2'd1;
                           bytes_in_line_in = bytes_in_line_in + 1'b1;
                        end
                        held_valid_in = 1'b1;
                     end else begin
                        if (held_valid_in) begin
                           if (bytes_in_line_in < declared_length_ff) begin
                              res[res_n[0]] = '{kind: KIND_DATA, value: CHAR_CR,
                                                param_index: 6'(param_counter_ff),
                                                last: 1'b0};
                              res_n = res_n + 2'd1;
                              bytes_in_line_in = bytes_in_line_in + 1'b1;
                           end
                           held_valid_in = 1'b0;
                        end
                        if (bytes_in_line_in < declared_length_ff) begin
                           res[res_n[0]] = '{kind: KIND_DATA, value: c,
                                             param_index: 6'(param_counter_ff), last: 1'b0};
                           res_n = res_n + 2'd1;
                           bytes_in_line_in = bytes_in_line_in + 1'b1;
                        end
                     end
                  end
               end
               if (nl || eoc) begin
                  if (line_kind_in == LK_LENGTH) begin
                     declared_length_in = (number_in > MaxLengthAcc) ? LenW'(MAX_LENGTH)
                                                                     : LenW'(number_in);
                  end else if (line_kind_in == LK_DATA) begin
                     held_valid_in = 1'b0;
                     res[res_n[0]] = '{kind: KIND_END, value: 8'd0,
                                       param_index: 6'(param_counter_ff), last: 1'b0};
                     res_n = res_n + 2'd1;
                     param_counter_in = param_counter_ff + 1'b1;
                  end
                  at_line_start_in = 1'b1;
               end
            end
            PH_IGNORE: begin
               content = 1'b0;
            end
            default: begin
               content = 1'b0;
            end
         endcase

         if (eoc) begin
            at_line_start_in   = 1'b1;
            line_kind_in       = LK_NONE;
            digits_done_in     = 1'b0;
            number_in          = '0;
            param_total_in     = '0;
            param_counter_in   = '0;
            declared_length_in = '0;
            bytes_in_line_in   = '0;
            held_valid_in      = 1'b0;
         end

         // mark the final result of this beat
         if (res_n == 2'd1) begin
            res[0].last = 1'b1;
         end else if (res_n == 2'd2) begin
            res[1].last = 1'b1;
         end
      end
   end

   always_comb begin
      head_in  = head_ff + (pop ? 2'd1 : 2'd0);
      count_in = count_ff + (accept ? {1'b0, res_n} : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         at_line_start_ff   <= 1'b1;
         line_kind_ff       <= LK_NONE;
         digits_done_ff     <= 1'b0;
         number_ff          <= '0;
         param_total_ff     <= '0;
         param_counter_ff   <= '0;
         declared_length_ff <= '0;
         bytes_in_line_ff   <= '0;
         held_valid_ff      <= 1'b0;
         head_ff            <= '0;
         count_ff           <= '0;
      end else begin
         phase_ff           <= phase_in;
         at_line_start_ff   <= at_line_start_in;
         line_kind_ff       <= line_kind_in;
         digits_done_ff     <= digits_done_in;
         number_ff          <= number_in;
         param_total_ff     <= param_total_in;
         param_counter_ff   <= param_counter_in;
         declared_length_ff <= declared_length_in;
         bytes_in_line_ff   <= bytes_in_line_in;
         held_valid_ff      <= held_valid_in;
         head_ff            <= head_in;
         count_ff           <= count_in;
      end
   end

   // queue payload, written at the tail
   always_ff @(posedge clock) begin
      logic [1:0] tail;
      tail = head_ff + count_ff[1:0];
      if (accept && (res_n != 2'd0)) begin
         queue_ff[tail] <= res[0];
         if (res_n == 2'd2) begin
            queue_ff[tail + 2'd1] <= res[1];
         end
      end
   end

endmodule

`default_nettype wire
